[sv/psg_register_stream_parser_unit_assert.svh]
// Assertion macros for the PSG register stream parser.
// Every property is clocked on clk and is off while rst_n is low.
`ifndef PSG_REGISTER_STREAM_PARSER_UNIT_ASSERT_SVH
`define PSG_REGISTER_STREAM_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSG_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/psg_pkg.sv]
package psg_pkg;

    // Default width of the byte position, the length register and the consumed count.
    localparam int LENGTH_BITS_DEFAULT = 24;

    // Fixed widths of the result fields.
    localparam int USED_LENGTH_WIDTH = 24;

    // Depth of the result queue and its derived widths.
    localparam int RESULT_DEPTH = 4;
    localparam int RESULT_PTR_W = $clog2(RESULT_DEPTH);
    localparam int RESULT_CNT_W = $clog2(RESULT_DEPTH + 1);

    // Body command bytes and limits.
    localparam logic [7:0] CMD_FRAME    = 8'hFF;
    localparam logic [7:0] CMD_SKIP     = 8'hFE;
    localparam logic [7:0] CMD_END      = 8'hFD;
    localparam logic [7:0] MAX_REGISTER = 8'd15;

    // Header layout.
    localparam int MIN_FILE_LENGTH = 16;
    localparam int SIG_END_POS     = 3;
    localparam int PAD_END_POS     = 15;
    localparam logic [4:0] SHORT_BODY_START = 5'd4;
    localparam logic [4:0] LONG_BODY_START  = 5'd16;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_HEADER   = 8'b0000_0001,
        PH_VERSION  = 8'b0000_0010,
        PH_PAD      = 8'b0000_0100,
        PH_CMD      = 8'b0000_1000,
        PH_SKIP_ARG = 8'b0001_0000,
        PH_REG_ARG  = 8'b0010_0000,
        PH_STOPPED  = 8'b0100_0000,
        PH_FINISHED = 8'b1000_0000
    } psg_phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_FRAMES    = 2'd0,
        KIND_REG_WRITE = 2'd1,
        KIND_SUMMARY   = 2'd2
    } psg_kind_t;

    // One result item.
    typedef struct packed {
        psg_kind_t                      event_kind;
        logic [9:0]                     frame_count;
        logic [3:0]                     chip_register;
        logic [7:0]                     register_value;
        logic                           accepted;
        logic [USED_LENGTH_WIDTH-1:0]   used_length;
        logic [4:0]                     body_start;
        logic                           last_of_run;
    } psg_result_t;

    // Results caused by one byte: up to an event and a summary, in that order.
    typedef struct packed {
        logic [1:0]  count;
        psg_result_t first;
        psg_result_t second;
    } psg_emit_t;

    // Result queue status.
    typedef struct packed {
        logic [RESULT_CNT_W-1:0] count;
        logic                    room;
    } psg_status_t;

    // Signature byte expected at header offsets zero to three.
    function automatic logic [7:0] psg_sig_byte(input logic [1:0] idx);
        logic [7:0] value;
        case (idx)
            2'd0:    value = 8'h50;
            2'd1:    value = 8'h53;
            2'd2:    value = 8'h47;
            default: value = 8'h1A;
        endcase
        return value;
    endfunction

endpackage

[sv/psg_register_stream_parser_unit.sv]
// Channel    Direction  Data bits                              Sideband
// s_axis     in         tdata[7:0] data_byte                   none
// m_axis     out        tdata[55:0] result fields, zero pad    tuser event_kind, tlast
// cfg        in         cfg_wr_data file_length                cfg_wr_en
//
// One byte is taken per cycle while the result queue has room for a pair; a byte waits
// in the input register until then, and its results enter the result queue at the edge that takes it out.
// A byte gives up to two results, and a pair leaves the queue one result at a time.
// The input register passes its byte on only while the queue has room for a pair.
// Reset puts the parser in its header phase and clears the queue and the length.
module psg_register_stream_parser_unit #(
    parameter int LENGTH_BITS = psg_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LENGTH_BITS-1:0] cfg_wr_data,   // file_length
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] data_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [9:0] frame_count, [13:10] chip_register, [21:14] register_value,
    // [22] accepted, [46:23] used_length, [51:47] body_start, [55:52] zero
    output logic [55:0]            m_axis_tdata,
    output logic [1:0]             m_axis_tuser,  // [1:0] event_kind
    output logic                   m_axis_tlast   // last_of_run
);
    import psg_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        parse_fire;
    psg_emit_t   emit;
    psg_result_t head;
    psg_status_t status;

    assign parse_fire    = in_valid_reg && status.room;
    assign s_axis_tready = !in_valid_reg || parse_fire;

    // Input register: holds one byte until the parser can take it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    psg_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (parse_fire),
        .byte_data   (in_byte_reg),
        .emit        (emit)
    );

    psg_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .pop        (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_result (head),
        .status     (status)
    );

    // Output transfer packing.
    assign m_axis_tdata = {4'b0000, head.body_start, head.used_length, head.accepted,
                           head.register_value, head.chip_register, head.frame_count};
    assign m_axis_tuser = head.event_kind;
    assign m_axis_tlast = head.last_of_run;

`include "psg_register_stream_parser_unit_assert.svh"

    `PSG_ASSERT_SAME(a_summary_is_last, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY),
        m_axis_tlast, "summary result without tlast")
    `PSG_ASSERT_SAME(a_pair_ends_in_summary, parse_fire && (emit.count == 2'd2),
        emit.second.event_kind == KIND_SUMMARY, "second result of a byte is not a summary")
    `PSG_ASSERT_SAME(a_queue_bound, 1'b1,
        status.count <= RESULT_CNT_W'(RESULT_DEPTH), "result queue overfilled")
    `PSG_ASSERT_NEXT(a_push_shows, parse_fire && (emit.count != 2'd0),
        m_axis_tvalid, "pushed result not offered")

endmodule

[sv/psg_parser.sv]
module psg_parser #(
    parameter int LENGTH_BITS = psg_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [LENGTH_BITS-1:0] cfg_wr_data,
    input  logic                   byte_valid,
    input  logic [7:0]             byte_data,
    output psg_pkg::psg_emit_t     emit
);
    import psg_pkg::*;

    localparam logic [LENGTH_BITS-1:0] POS_ONE   = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] MIN_LEN   = LENGTH_BITS'(MIN_FILE_LENGTH);
    localparam logic [LENGTH_BITS-1:0] SIG_END   = LENGTH_BITS'(SIG_END_POS);
    localparam logic [LENGTH_BITS-1:0] PAD_END   = LENGTH_BITS'(PAD_END_POS);

    psg_phase_t             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] file_length_reg;
    logic [LENGTH_BITS-1:0] byte_position_reg, byte_position_next;
    logic [LENGTH_BITS-1:0] consumed_length_reg, consumed_length_next;
    logic                   header_good_reg, header_good_next;
    logic                   short_body_start_reg, short_body_start_next;
    logic [3:0]             pending_register_reg, pending_register_next;

    logic [LENGTH_BITS-1:0] pos_inc;
    logic                   final_byte;
    logic                   length_ok;
    logic                   active;
    logic                   ev_valid;
    psg_result_t            ev;
    psg_result_t            summary;
    logic [31:0]            consumed_wide;

    assign pos_inc    = byte_position_reg + POS_ONE;
    assign final_byte = (pos_inc == file_length_reg);
    assign length_ok  = (file_length_reg > MIN_LEN);
    assign active     = byte_valid && (phase_reg != PH_FINISHED);

    // Phase update and body event for the byte in the input register.
    always_comb
    begin
        phase_next            = phase_reg;
        byte_position_next    = byte_position_reg;
        consumed_length_next  = consumed_length_reg;
        header_good_next      = header_good_reg;
        short_body_start_next = short_body_start_reg;
        pending_register_next = pending_register_reg;
        ev_valid              = 1'b0;
        ev                    = '0;
        if (active)
        begin
            header_good_next   = header_good_reg && length_ok;
            byte_position_next = pos_inc;
            if (header_good_next)
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (byte_data != psg_sig_byte(byte_position_reg[1:0]))
                        begin
                            header_good_next = 1'b0;
                        end
                        else
                        begin
                            consumed_length_next = pos_inc;
                            if (byte_position_reg >= SIG_END)
                            begin
                                phase_next = PH_VERSION;
                            end
                        end
                    end
                    PH_VERSION:
                    begin
                        consumed_length_next = pos_inc;
                        if (byte_data == CMD_FRAME)
                        begin
                            short_body_start_next = 1'b1;
                            ev_valid              = 1'b1;
                            ev.event_kind         = KIND_FRAMES;
                            ev.frame_count        = 10'd1;
                            phase_next            = PH_CMD;
                        end
                        else
                        begin
                            short_body_start_next = 1'b0;
                            phase_next            = PH_PAD;
                        end
                    end
                    PH_PAD:
                    begin
                        consumed_length_next = pos_inc;
                        if (byte_position_reg >= PAD_END)
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        if (byte_data == CMD_FRAME)
                        begin
                            consumed_length_next = pos_inc;
                            ev_valid             = 1'b1;
                            ev.event_kind        = KIND_FRAMES;
                            ev.frame_count       = 10'd1;
                        end
                        else if (byte_data == CMD_SKIP)
                        begin
                            phase_next = PH_SKIP_ARG;
                        end
                        else if (byte_data == CMD_END)
                        begin
                            consumed_length_next = pos_inc;
                            phase_next           = PH_STOPPED;
                        end
                        else if (byte_data <= MAX_REGISTER)
                        begin
                            pending_register_next = byte_data[3:0];
                            phase_next            = PH_REG_ARG;
                        end
                        else
                        begin
                            phase_next = PH_STOPPED;
                        end
                    end
                    PH_SKIP_ARG:
                    begin
                        consumed_length_next = pos_inc;
                        ev_valid             = 1'b1;
                        ev.event_kind        = KIND_FRAMES;
                        ev.frame_count       = {byte_data, 2'b00};
                        phase_next           = PH_CMD;
                    end
                    PH_REG_ARG:
                    begin
                        consumed_length_next = pos_inc;
                        ev_valid             = 1'b1;
                        ev.event_kind        = KIND_REG_WRITE;
                        ev.chip_register     = pending_register_reg;
                        ev.register_value    = byte_data;
                        phase_next           = PH_CMD;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            if (final_byte)
            begin
                phase_next = PH_FINISHED;
            end
        end
    end

    // End-of-file summary built from the updated state.
    assign consumed_wide = 32'(consumed_length_next);

    always_comb
    begin
        summary            = '0;
        summary.event_kind = KIND_SUMMARY;
        if (header_good_next)
        begin
            summary.accepted    = 1'b1;
            summary.used_length = consumed_wide[USED_LENGTH_WIDTH-1:0];
            summary.body_start  = short_body_start_next ? SHORT_BODY_START : LONG_BODY_START;
        end
    end

    // Order the results of this byte and mark the final one.
    always_comb
    begin
        emit = '0;
        if (active)
        begin
            if (ev_valid && final_byte)
            begin
                emit.count              = 2'd2;
                emit.first              = ev;
                emit.second             = summary;
                emit.second.last_of_run = 1'b1;
            end
            else if (ev_valid)
            begin
                emit.count             = 2'd1;
                emit.first             = ev;
                emit.first.last_of_run = 1'b1;
            end
            else if (final_byte)
            begin
                emit.count             = 2'd1;
                emit.first             = summary;
                emit.first.last_of_run = 1'b1;
            end
        end
    end

    // Parser state and length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HEADER;
            file_length_reg      <= '0;
            byte_position_reg    <= '0;
            consumed_length_reg  <= '0;
            header_good_reg      <= 1'b1;
            short_body_start_reg <= 1'b0;
            pending_register_reg <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            byte_position_reg    <= byte_position_next;
            consumed_length_reg  <= consumed_length_next;
            header_good_reg      <= header_good_next;
            short_body_start_reg <= short_body_start_next;
            pending_register_reg <= pending_register_next;
            if (cfg_wr_en)
            begin
                file_length_reg <= cfg_wr_data;
            end
        end
    end

endmodule

[sv/psg_result_fifo.sv]
module psg_result_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psg_pkg::psg_emit_t   emit,
    input  logic                 pop,
    output logic                 out_valid,
    output psg_pkg::psg_result_t out_result,
    output psg_pkg::psg_status_t status
);
    import psg_pkg::*;

    psg_result_t              entry_reg [RESULT_DEPTH];
    logic [RESULT_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RESULT_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RESULT_CNT_W-1:0]  count_reg, count_next;
    logic [RESULT_PTR_W-1:0]  wr_ptr_inc;
    logic                     do_pop;

    assign out_valid  = (count_reg != '0);
    assign out_result = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && out_valid;
    assign wr_ptr_inc = wr_ptr_reg + RESULT_PTR_W'(1);

    // Room for a full pair of results from the next byte.
    assign status.count = count_reg;
    assign status.room  = (count_reg <= RESULT_CNT_W'(RESULT_DEPTH - 2));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RESULT_PTR_W'(emit.count);
        rd_ptr_next = do_pop ? rd_ptr_reg + RESULT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + RESULT_CNT_W'(emit.count) - RESULT_CNT_W'(do_pop);
    end

    // Result storage, written with up to two entries per cycle.
    always_ff @(posedge clk)
    begin
        if (emit.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= emit.first;
        end
        if (emit.count == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= emit.second;
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[test/psg_register_stream_parser_unit_tb.sv]
module psg_register_stream_parser_unit_tb;

    import psg_pkg::*;

    localparam int LEN_W         = LENGTH_BITS_DEFAULT;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TABLE_ROWS    = 21;
    localparam int VERSION_ROW   = SIG_END_POS + 1;
    localparam int PAD_BYTES     = PAD_END_POS - VERSION_ROW;
    localparam int BODY_BYTES    = 1000;

    localparam logic [7:0] SIGNATURE [4] = '{8'h50, 8'h53, 8'h47, 8'h1A};

    // One row of the directed stimulus: the byte, and optionally the result it must give.
    typedef struct {
        logic [7:0]  data;
        bit          typed;
        bit          gives_result;
        psg_result_t outcome;
    } table_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [55:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;

    // Parser state as the testbench tracks it.
    logic [LEN_W-1:0] dump_length;
    logic [LEN_W-1:0] dump_pos;
    psg_phase_t       dump_phase;
    logic             header_ok;
    logic             short_header;
    logic [3:0]       held_register;
    logic [LEN_W-1:0] used_bytes;

    // Results of the latest byte, and the results still owed by the block.
    psg_result_t byte_outcome [2];
    int          outcome_count;
    psg_result_t pending_events [$];
    logic [7:0]  byte_plan [$];

    table_row_t stim_table [TABLE_ROWS];

    int mismatch_count = 0;
    int cycle_count = 0;
    bit sender_idles;
    bit receiver_idles;
    bit hold_receiver;

    psg_register_stream_parser_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    function automatic psg_result_t make_frames(input logic [9:0] ticks);
        psg_result_t r;
        r             = '0;
        r.event_kind  = KIND_FRAMES;
        r.frame_count = ticks;
        return r;
    endfunction

    function automatic psg_result_t make_write(input logic [3:0] idx, input logic [7:0] value);
        psg_result_t r;
        r                = '0;
        r.event_kind     = KIND_REG_WRITE;
        r.chip_register  = idx;
        r.register_value = value;
        return r;
    endfunction

    function automatic table_row_t make_row(input logic [7:0] data, input bit typed,
                                            input bit gives_result, input psg_result_t outcome);
        table_row_t row;
        row.data         = data;
        row.typed        = typed;
        row.gives_result = gives_result;
        row.outcome      = outcome;
        return row;
    endfunction

    // Advance the tracked parser by one byte and leave its results in byte_outcome.
    function automatic void predict_dump_byte(input logic [7:0] b);
        logic [LEN_W-1:0] next_pos;
        logic             last_byte;
        psg_result_t      summary;
        outcome_count = 0;
        if (dump_phase == PH_FINISHED)
            return;
        next_pos  = dump_pos + 1'b1;
        last_byte = (next_pos == dump_length);
        // A short length rejects the file from this byte on, for good.
        if (dump_length <= MIN_FILE_LENGTH)
            header_ok = 1'b0;
        if (header_ok)
        begin
            case (dump_phase)
                PH_HEADER:
                begin
                    if (b != SIGNATURE[dump_pos[1:0]])
                        header_ok = 1'b0;
                    else
                    begin
                        used_bytes = next_pos;
                        if (dump_pos >= SIG_END_POS)
                            dump_phase = PH_VERSION;
                    end
                end
                PH_VERSION:
                begin
                    used_bytes   = next_pos;
                    short_header = (b == CMD_FRAME);
                    if (b == CMD_FRAME)
                    begin
                        byte_outcome[outcome_count] = make_frames(10'd1);
                        outcome_count++;
                        dump_phase = PH_CMD;
                    end
                    else
                        dump_phase = PH_PAD;
                end
                PH_PAD:
                begin
                    used_bytes = next_pos;
                    if (dump_pos >= PAD_END_POS)
                        dump_phase = PH_CMD;
                end
                PH_CMD:
                begin
                    if (b == CMD_FRAME)
                    begin
                        used_bytes = next_pos;
                        byte_outcome[outcome_count] = make_frames(10'd1);
                        outcome_count++;
                    end
                    else if (b == CMD_SKIP)
                        dump_phase = PH_SKIP_ARG;
                    else if (b == CMD_END)
                    begin
                        used_bytes = next_pos;
                        dump_phase = PH_STOPPED;
                    end
                    else if (b <= MAX_REGISTER)
                    begin
                        held_register = b[3:0];
                        dump_phase    = PH_REG_ARG;
                    end
                    else
                        dump_phase = PH_STOPPED;
                end
                PH_SKIP_ARG:
                begin
                    used_bytes = next_pos;
                    byte_outcome[outcome_count] = make_frames({b, 2'b00});
                    outcome_count++;
                    dump_phase = PH_CMD;
                end
                PH_REG_ARG:
                begin
                    used_bytes = next_pos;
                    byte_outcome[outcome_count] = make_write(held_register, b);
                    outcome_count++;
                    dump_phase = PH_CMD;
                end
                default:
                begin
                end
            endcase
        end
        dump_pos = next_pos;
        // The final byte of the file closes it with a summary.
        if (last_byte)
        begin
            summary            = '0;
            summary.event_kind = KIND_SUMMARY;
            summary.accepted   = header_ok;
            if (header_ok)
            begin
                summary.used_length = used_bytes;
                summary.body_start  = short_header ? SHORT_BODY_START : LONG_BODY_START;
            end
            byte_outcome[outcome_count] = summary;
            outcome_count++;
            dump_phase = PH_FINISHED;
        end
        for (int i = 0; i < outcome_count; i++)
            byte_outcome[i].last_of_run = (i == outcome_count - 1);
    endfunction

    function automatic void queue_prediction();
        for (int i = 0; i < outcome_count; i++)
            pending_events.push_back(byte_outcome[i]);
    endfunction

    // Append one well-formed body command with random content.
    function automatic void plan_command();
        int         pick;
        logic [7:0] arg;
        pick = $urandom_range(0, 9);
        case ($urandom_range(0, 7))
            0:       arg = 8'h00;
            1:       arg = 8'hFF;
            default: arg = 8'($urandom_range(0, 255));
        endcase
        if (pick < 3)
            byte_plan.push_back(CMD_FRAME);
        else if (pick < 6)
        begin
            byte_plan.push_back(CMD_SKIP);
            byte_plan.push_back(arg);
        end
        else
        begin
            byte_plan.push_back(8'($urandom_range(0, 15)));
            byte_plan.push_back(arg);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen_val,
                                   input logic [31:0] want_val);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, seen_val,
                     want_val);
    endtask

    // Offer one byte until the block takes the transfer, then track its effect.
    task automatic offer_byte(input logic [7:0] value);
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_dump_byte(value);
    endtask

    task automatic send_byte(input logic [7:0] value);
        offer_byte(value);
        queue_prediction();
    endtask

    task automatic send_plan();
        while (byte_plan.size() != 0)
            send_byte(byte_plan.pop_front());
    endtask

    // Stop offering bytes and let every owed result drain out.
    task automatic quiesce();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        dump_length = value;
    endtask

    // Run time limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("psg_register_stream_parser_unit verification failed");
            $finish;
        end
    end

    // Result side: random stalls, and one long hold-off on request.
    initial
    begin : result_sink
        int stall;
        bit hold_served;
        hold_served = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver && !hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 12);
                repeat (stall) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest owed result.
    always @(posedge clk)
    begin : result_monitor
        psg_result_t seen;
        psg_result_t wanted;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.event_kind     = psg_kind_t'(m_axis_tuser);
            seen.frame_count    = m_axis_tdata[9:0];
            seen.chip_register  = m_axis_tdata[13:10];
            seen.register_value = m_axis_tdata[21:14];
            seen.accepted       = m_axis_tdata[22];
            seen.used_length    = m_axis_tdata[46:23];
            seen.body_start     = m_axis_tdata[51:47];
            seen.last_of_run    = m_axis_tlast;
            if (pending_events.size() == 0)
                report_mismatch("unexpected result, kind", 32'(seen.event_kind), 0);
            else
            begin
                wanted = pending_events.pop_front();
                if (seen.event_kind != wanted.event_kind)
                    report_mismatch("event_kind", 32'(seen.event_kind),
                                    32'(wanted.event_kind));
                if (seen.frame_count != wanted.frame_count)
                    report_mismatch("frame_count", 32'(seen.frame_count),
                                    32'(wanted.frame_count));
                if (seen.chip_register != wanted.chip_register)
                    report_mismatch("chip_register", 32'(seen.chip_register),
                                    32'(wanted.chip_register));
                if (seen.register_value != wanted.register_value)
                    report_mismatch("register_value", 32'(seen.register_value),
                                    32'(wanted.register_value));
                if (seen.accepted != wanted.accepted)
                    report_mismatch("accepted", 32'(seen.accepted), 32'(wanted.accepted));
                if (seen.used_length != wanted.used_length)
                    report_mismatch("used_length", 32'(seen.used_length),
                                    32'(wanted.used_length));
                if (seen.body_start != wanted.body_start)
                    report_mismatch("body_start", 32'(seen.body_start),
                                    32'(wanted.body_start));
                if (seen.last_of_run != wanted.last_of_run)
                    report_mismatch("last_of_run", 32'(seen.last_of_run),
                                    32'(wanted.last_of_run));
                if (m_axis_tdata[55:52] != 4'd0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[55:52]), 0);
            end
        end
    end

    initial
    begin : stimulus
        table_row_t       row;
        psg_result_t      typed_result;
        logic [LEN_W-1:0] new_length;
        bit               sig_broken;
        bit               long_header;
        int               broken_at;
        int               body_target;
        int               body_sent;
        int               ending;
        bit               hold_done;
        bit               pause_done;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        hold_receiver  = 1'b0;
        dump_length    = '0;
        dump_pos       = '0;
        dump_phase     = PH_HEADER;
        header_ok      = 1'b1;
        short_header   = 1'b0;
        held_register  = '0;
        used_bytes     = '0;
        outcome_count  = 0;

        // Header, then the frame, skip and register commands with their argument extremes.
        stim_table[0]  = make_row(SIGNATURE[0], 1'b1, 1'b0, '0);
        stim_table[1]  = make_row(SIGNATURE[1], 1'b1, 1'b0, '0);
        stim_table[2]  = make_row(SIGNATURE[2], 1'b1, 1'b0, '0);
        stim_table[3]  = make_row(SIGNATURE[3], 1'b1, 1'b0, '0);
        stim_table[4]  = make_row(CMD_FRAME, 1'b1, 1'b1, make_frames(10'd1));
        stim_table[5]  = make_row(CMD_FRAME, 1'b1, 1'b1, make_frames(10'd1));
        stim_table[6]  = make_row(CMD_SKIP, 1'b1, 1'b0, '0);
        stim_table[7]  = make_row(8'h00, 1'b1, 1'b1, make_frames(10'd0));
        stim_table[8]  = make_row(CMD_SKIP, 1'b1, 1'b0, '0);
        stim_table[9]  = make_row(8'hFF, 1'b1, 1'b1, make_frames(10'd1020));
        stim_table[10] = make_row(8'h00, 1'b1, 1'b0, '0);
        stim_table[11] = make_row(8'h00, 1'b1, 1'b1, make_write(4'd0, 8'h00));
        stim_table[12] = make_row(8'h0F, 1'b1, 1'b0, '0);
        stim_table[13] = make_row(8'hFF, 1'b1, 1'b1, make_write(4'd15, 8'hFF));
        stim_table[14] = make_row(CMD_SKIP, 1'b0, 1'b0, '0);
        stim_table[15] = make_row(CMD_END, 1'b0, 1'b0, '0);
        stim_table[16] = make_row(8'h03, 1'b0, 1'b0, '0);
        stim_table[17] = make_row(CMD_END, 1'b0, 1'b0, '0);
        stim_table[18] = make_row(8'h0A, 1'b0, 1'b0, '0);
        stim_table[19] = make_row(8'h80, 1'b0, 1'b0, '0);
        stim_table[20] = make_row(CMD_FRAME, 1'b0, 1'b0, '0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Only one file fits in a run, so its header shape is drawn per run.
        sig_broken  = ($urandom_range(0, 7) == 0);
        broken_at   = $urandom_range(0, SIG_END_POS);
        long_header = 1'($urandom_range(0, 1));
        write_length({LEN_W{1'b1}});

        // Directed part.
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            row = stim_table[i];
            if (sig_broken && i == broken_at)
                row.data = row.data ^ 8'($urandom_range(1, 255));
            if (i == VERSION_ROW && long_header)
            begin
                send_byte(8'($urandom_range(0, 254)));
                repeat (PAD_BYTES) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                offer_byte(row.data);
                if (row.typed && !sig_broken)
                begin
                    if (row.gives_result)
                    begin
                        typed_result             = row.outcome;
                        typed_result.last_of_run = 1'b1;
                        pending_events.push_back(typed_result);
                    end
                end
                else
                    queue_prediction();
            end
        end

        // Random body of well-formed commands.
        body_target = BODY_BYTES;
        body_sent   = 0;
        hold_done   = 1'b0;
        pause_done  = 1'b0;
        while (body_sent < body_target)
        begin
            if (!hold_done && body_sent >= body_target / 3)
            begin
                hold_receiver = 1'b1;
                hold_done     = 1'b1;
            end
            if (!pause_done && body_sent >= body_target / 2)
            begin
                quiesce();
                new_length = LEN_W'(dump_pos + 5000 + $urandom_range(0, 1000000));
                write_length(new_length);
                pause_done = 1'b1;
            end
            if (body_sent >= body_target * 4 / 5)
            begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end
            plan_command();
            body_sent += byte_plan.size();
            send_plan();
        end

        // Close the file in one of several ways.
        ending = $urandom_range(0, 4);
        quiesce();
        if (ending == 4)
        begin
            // A short length rejects the file even after a good header.
            write_length(LEN_W'($urandom_range(0, MIN_FILE_LENGTH)));
            repeat (2) plan_command();
            send_plan();
            quiesce();
        end
        repeat ($urandom_range(0, 3)) plan_command();
        case (ending)
            1:
            begin
                byte_plan.push_back(8'($urandom_range(0, 15)));
                byte_plan.push_back(8'($urandom_range(0, 255)));
            end
            2:
                // Command whose argument would fall beyond the file.
                byte_plan.push_back($urandom_range(0, 1) ? CMD_SKIP : 8'($urandom_range(0, 15)));
            3:
            begin
                // Parsing stops; later bytes only advance the position.
                byte_plan.push_back($urandom_range(0, 1) ? CMD_END : 8'($urandom_range(16, 252)));
                repeat ($urandom_range(0, 5)) byte_plan.push_back(8'($urandom_range(0, 255)));
            end
            default:
                byte_plan.push_back(CMD_FRAME);
        endcase
        new_length = LEN_W'(dump_pos + byte_plan.size());
        write_length(new_length);
        send_plan();

        // Bytes after the summary are dropped without results.
        quiesce();
        write_length('0);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        quiesce();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("psg_register_stream_parser_unit verification clean");
        else
            $display("psg_register_stream_parser_unit verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/psg_pkg.sv
sv/psg_parser.sv
sv/psg_result_fifo.sv
sv/psg_register_stream_parser_unit.sv
test/psg_register_stream_parser_unit_tb.sv
